// ===== design/stwl_pkg.sv =====
// Shared types and constants for the slot table with id lookup.
// Used by stwl_rec_mem and slot_table_with_id_lookup_core; no dependencies.
`timescale 1ns / 1ps
package stwl_pkg;

  localparam int TABLE_SLOTS = 64;
  localparam int IDX_W       = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
  localparam int KEY_W       = 16;
  localparam int SLOT_IDX_W  = 6;
  localparam int CMD_W       = 3;
  localparam int STATUS_W    = 2;

  localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(TABLE_SLOTS - 1);
  localparam logic [KEY_W-1:0] ID_MAX    = '1;

  typedef enum logic [CMD_W-1:0] {
    CMD_CLEAR     = 3'd0,
    CMD_INSERT    = 3'd1,
    CMD_DELETE    = 3'd2,
    CMD_FIND_ID   = 3'd3,
    CMD_FIND_AUTH = 3'd4,
    CMD_UPDATE    = 3'd5
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2,
    ST_EXHAUSTED = 2'd3
  } status_e;

  typedef struct packed {
    logic [KEY_W-1:0] id;
    logic [KEY_W-1:0] author;
  } record_t;

endpackage

// ===== design/stwl_rec_mem.sv =====
// Record store: one id/author pair per slot, one read and one write port.
// Read data is registered. Depends on stwl_pkg.
`timescale 1ns / 1ps
module stwl_rec_mem import stwl_pkg::*; (
  input  logic             clk_i,
  input  logic             rd_en_i,
  input  logic [IDX_W-1:0] rd_addr_i,
  output record_t          rd_data_o,
  input  logic             wr_en_i,
  input  logic [IDX_W-1:0] wr_addr_i,
  input  record_t          wr_data_i
);

  record_t mem_q [TABLE_SLOTS];
  record_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== design/slot_table_with_id_lookup_core.sv =====
// Slot table with id lookup: valid bits in flops, id/author pairs in stwl_rec_mem.
// Scan commands walk the memory one slot per cycle. Clear and unused commands
// answer in the cycle after the request. One request at a time; busy is low
// again in the cycle the result is shown. The receiver cannot stall.
// Asynchronous active-low reset empties all slots and zeroes the id counter.
`timescale 1ns / 1ps
module slot_table_with_id_lookup_core import stwl_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start,
  output logic                  busy,
  input  logic [CMD_W-1:0]      command_i,
  input  logic [KEY_W-1:0]      key_i,
  input  logic [KEY_W-1:0]      author_code_i,
  output logic                  done_o,
  output logic [STATUS_W-1:0]   status_o,
  output logic [SLOT_IDX_W-1:0] slot_index_o,
  output logic [KEY_W-1:0]      entry_id_o,
  output logic [KEY_W-1:0]      entry_author_o
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_SCAN = 2'b10
  } state_e;

  state_e                state_q, state_d;
  logic [CMD_W-1:0]      cmd_q, cmd_d;
  logic [KEY_W-1:0]      key_q, key_d;
  logic [KEY_W-1:0]      au_q, au_d;
  logic [KEY_W-1:0]      cnt_q, cnt_d;
  logic [TABLE_SLOTS-1:0] valid_q, valid_d;

  logic [IDX_W-1:0]      addr_q, addr_d;
  logic                  issue_q, issue_d;
  logic                  pv_q, pv_d;
  logic [IDX_W-1:0]      pidx_q, pidx_d;

  // first slot removed by a delete
  logic                  found_q, found_d;
  logic [IDX_W-1:0]      fidx_q, fidx_d;
  record_t               frec_q, frec_d;

  logic                  done_q, done_d;
  logic [STATUS_W-1:0]   status_q, status_d;
  logic [SLOT_IDX_W-1:0] sidx_q, sidx_d;
  logic [KEY_W-1:0]      eid_q, eid_d;
  logic [KEY_W-1:0]      eau_q, eau_d;

  record_t               rd_rec;
  logic                  wr_en;
  record_t               wr_rec;
  logic                  rd_en;

  logic                  cur_valid;
  logic                  hit;
  logic                  last;

  stwl_rec_mem u_mem (
    .clk_i     (clk_i),
    .rd_en_i   (rd_en),
    .rd_addr_i (addr_q),
    .rd_data_o (rd_rec),
    .wr_en_i   (wr_en),
    .wr_addr_i (pidx_q),
    .wr_data_i (wr_rec)
  );

  assign rd_en     = (state_q == S_SCAN) && issue_q;
  assign cur_valid = valid_q[pidx_q];
  assign last      = (pidx_q == LAST_SLOT);

  always_comb begin
    if (cmd_q == CMD_INSERT) begin
      hit = !cur_valid;
    end else if (cmd_q == CMD_FIND_AUTH) begin
      hit = cur_valid && (rd_rec.author == key_q);
    end else begin
      hit = cur_valid && (rd_rec.id == key_q);
    end
  end

  always_comb begin
    state_d  = state_q;
    cmd_d    = cmd_q;
    key_d    = key_q;
    au_d     = au_q;
    cnt_d    = cnt_q;
    valid_d  = valid_q;
    addr_d   = addr_q;
    issue_d  = issue_q;
    pv_d     = 1'b0;
    pidx_d   = addr_q;
    found_d  = found_q;
    fidx_d   = fidx_q;
    frec_d   = frec_q;
    done_d   = 1'b0;
    status_d = status_q;
    sidx_d   = sidx_q;
    eid_d    = eid_q;
    eau_d    = eau_q;
    wr_en    = 1'b0;
    wr_rec   = '{id: rd_rec.id, author: au_q};

    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          cmd_d = command_i;
          key_d = key_i;
          au_d  = author_code_i;
          unique case (command_i)
            CMD_CLEAR: begin
              valid_d  = '0;
              done_d   = 1'b1;
              status_d = ST_OK;
              sidx_d   = '0;
              eid_d    = '0;
              eau_d    = '0;
            end
            CMD_INSERT, CMD_DELETE, CMD_FIND_ID, CMD_FIND_AUTH, CMD_UPDATE: begin
              state_d = S_SCAN;
              addr_d  = '0;
              issue_d = 1'b1;
              found_d = 1'b0;
            end
            default: begin
              done_d   = 1'b1;
              status_d = ST_NOT_FOUND;
              sidx_d   = '0;
              eid_d    = '0;
              eau_d    = '0;
            end
          endcase
        end
      end
      S_SCAN: begin
        if (issue_q) begin
          pv_d   = 1'b1;
          pidx_d = addr_q;
          addr_d = addr_q + IDX_W'(1);
          if (addr_q == LAST_SLOT) begin
            issue_d = 1'b0;
          end
        end
        if (pv_q) begin
          // defaults for a miss at the end of the scan
          status_d = ST_NOT_FOUND;
          sidx_d   = '0;
          eid_d    = '0;
          eau_d    = '0;
          unique case (cmd_q)
            CMD_INSERT: begin
              if (hit) begin
                done_d = 1'b1;
                if (cnt_q == ID_MAX) begin
                  status_d = ST_EXHAUSTED;
                end else begin
                  cnt_d           = cnt_q + KEY_W'(1);
                  valid_d[pidx_q] = 1'b1;
                  wr_en           = 1'b1;
                  wr_rec          = '{id: cnt_q + KEY_W'(1), author: au_q};
                  status_d        = ST_OK;
                  sidx_d          = SLOT_IDX_W'(pidx_q);
                  eid_d           = cnt_q + KEY_W'(1);
                  eau_d           = au_q;
                end
              end else if (last) begin
                done_d   = 1'b1;
                status_d = ST_FULL;
              end
            end
            CMD_DELETE: begin
              if (hit) begin
                valid_d[pidx_q] = 1'b0;
                if (!found_q) begin
                  found_d = 1'b1;
                  fidx_d  = pidx_q;
                  frec_d  = rd_rec;
                end
              end
              if (last) begin
                done_d = 1'b1;
                if (found_q) begin
                  status_d = ST_OK;
                  sidx_d   = SLOT_IDX_W'(fidx_q);
                  eid_d    = frec_q.id;
                  eau_d    = frec_q.author;
                end else if (hit) begin
                  status_d = ST_OK;
                  sidx_d   = SLOT_IDX_W'(pidx_q);
                  eid_d    = rd_rec.id;
                  eau_d    = rd_rec.author;
                end
              end
            end
            CMD_FIND_ID, CMD_FIND_AUTH: begin
              if (hit) begin
                done_d   = 1'b1;
                status_d = ST_OK;
                sidx_d   = SLOT_IDX_W'(pidx_q);
                eid_d    = rd_rec.id;
                eau_d    = rd_rec.author;
              end else if (last) begin
                done_d = 1'b1;
              end
            end
            CMD_UPDATE: begin
              if (hit) begin
                done_d   = 1'b1;
                wr_en    = 1'b1;
                status_d = ST_OK;
                sidx_d   = SLOT_IDX_W'(pidx_q);
                eid_d    = rd_rec.id;
                eau_d    = au_q;
              end else if (last) begin
                done_d = 1'b1;
              end
            end
            default: begin
              done_d = 1'b1;
            end
          endcase
          if (done_d) begin
            // drop any read still in flight
            state_d = S_IDLE;
            issue_d = 1'b0;
            pv_d    = 1'b0;
          end else begin
            status_d = status_q;
            sidx_d   = sidx_q;
            eid_d    = eid_q;
            eau_d    = eau_q;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      valid_q <= '0;
      issue_q <= 1'b0;
      pv_q    <= 1'b0;
      found_q <= 1'b0;
      done_q  <= 1'b0;
      addr_q  <= '0;
      pidx_q  <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      valid_q <= valid_d;
      issue_q <= issue_d;
      pv_q    <= pv_d;
      found_q <= found_d;
      done_q  <= done_d;
      addr_q  <= addr_d;
      pidx_q  <= pidx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q    <= cmd_d;
    key_q    <= key_d;
    au_q     <= au_d;
    fidx_q   <= fidx_d;
    frec_q   <= frec_d;
    status_q <= status_d;
    sidx_q   <= sidx_d;
    eid_q    <= eid_d;
    eau_q    <= eau_d;
  end

  assign busy           = (state_q != S_IDLE);
  assign done_o         = done_q;
  assign status_o       = status_q;
  assign slot_index_o   = sidx_q;
  assign entry_id_o     = eid_q;
  assign entry_author_o = eau_q;

endmodule

// ===== sim/tb_top.sv =====
// Testbench for slot_table_with_id_lookup_core: random and directed requests checked
// against a behavioral model of the slot table. Depends on stwl_pkg and the core RTL.
`timescale 1ns / 1ps
module tb_top import stwl_pkg::*; ();

  localparam logic [CMD_W-1:0] CMD_UNUSED_LO = 3'd6;
  localparam logic [CMD_W-1:0] CMD_UNUSED_HI = 3'd7;

  typedef struct {
    status_e               st;
    logic [SLOT_IDX_W-1:0] idx;
    logic [KEY_W-1:0]      id;
    logic [KEY_W-1:0]      author;
  } answer_t;

  class slot_scoreboard;
    bit   [TABLE_SLOTS-1:0] valid;
    logic [KEY_W-1:0]       ids     [TABLE_SLOTS];
    logic [KEY_W-1:0]       authors [TABLE_SLOTS];
    logic [KEY_W-1:0]       id_count;
    answer_t                pending [$];
    int                     errors;

    function new();
      valid    = '0;
      id_count = '0;
      errors   = 0;
      foreach (ids[i]) begin
        ids[i]     = '0;
        authors[i] = '0;
      end
    endfunction

    function void queue_answer(status_e st, int s, logic [KEY_W-1:0] id,
                               logic [KEY_W-1:0] au);
      answer_t a;
      a.st     = st;
      a.idx    = SLOT_IDX_W'(s);
      a.id     = id;
      a.author = au;
      pending.push_back(a);
    endfunction

    function int lowest_match(bit by_author, logic [KEY_W-1:0] v);
      for (int i = 0; i < TABLE_SLOTS; i++)
        if (valid[i] && (by_author ? authors[i] : ids[i]) == v) return i;
      return -1;
    endfunction

    // Updates the table copy and queues the answer this request must produce.
    function void note_request(logic [CMD_W-1:0] cmd, logic [KEY_W-1:0] key,
                               logic [KEY_W-1:0] au);
      int s;
      s = -1;
      case (cmd)
        CMD_CLEAR: begin
          valid = '0;
          queue_answer(ST_OK, 0, '0, '0);
        end
        CMD_INSERT: begin
          for (int i = 0; i < TABLE_SLOTS && s < 0; i++)
            if (!valid[i]) s = i;
          // full takes precedence over an exhausted counter
          if (s < 0) begin
            queue_answer(ST_FULL, 0, '0, '0);
          end else if (id_count == ID_MAX) begin
            queue_answer(ST_EXHAUSTED, 0, '0, '0);
          end else begin
            id_count   = id_count + 1'b1;
            valid[s]   = 1'b1;
            ids[s]     = id_count;
            authors[s] = au;
            queue_answer(ST_OK, s, id_count, au);
          end
        end
        CMD_DELETE: begin
          for (int i = 0; i < TABLE_SLOTS; i++) begin
            if (valid[i] && ids[i] == key) begin
              if (s < 0) begin
                s = i;
                queue_answer(ST_OK, i, ids[i], authors[i]);
              end
              valid[i]   = 1'b0;
              ids[i]     = '0;
              authors[i] = '0;
            end
          end
          if (s < 0) queue_answer(ST_NOT_FOUND, 0, '0, '0);
        end
        CMD_FIND_ID, CMD_FIND_AUTH: begin
          s = lowest_match(cmd == CMD_FIND_AUTH, key);
          if (s < 0) queue_answer(ST_NOT_FOUND, 0, '0, '0);
          else       queue_answer(ST_OK, s, ids[s], authors[s]);
        end
        CMD_UPDATE: begin
          s = lowest_match(1'b0, key);
          if (s < 0) begin
            queue_answer(ST_NOT_FOUND, 0, '0, '0);
          end else begin
            authors[s] = au;
            queue_answer(ST_OK, s, ids[s], au);
          end
        end
        default: queue_answer(ST_NOT_FOUND, 0, '0, '0);
      endcase
    endfunction

    task report(string msg);
      $display("%0t MISMATCH: %s", $time, msg);
      errors++;
    endtask

    task check_result(logic [STATUS_W-1:0] st, logic [SLOT_IDX_W-1:0] idx,
                      logic [KEY_W-1:0] id, logic [KEY_W-1:0] au);
      answer_t a;
      if (pending.size() == 0) begin
        report($sformatf("result with no request pending: status %0d slot %0d", st, idx));
        return;
      end
      a = pending.pop_front();
      if (st !== a.st)
        report($sformatf("status got %0d want %0d", st, a.st));
      if (idx !== a.idx)
        report($sformatf("slot_index got %0d want %0d", idx, a.idx));
      if (id !== a.id)
        report($sformatf("entry_id got %h want %h", id, a.id));
      if (au !== a.author)
        report($sformatf("entry_author got %h want %h", au, a.author));
    endtask
  endclass

  logic                  clk_i;
  logic                  rst_ni;
  logic                  start;
  logic                  busy;
  logic [CMD_W-1:0]      command_i;
  logic [KEY_W-1:0]      key_i;
  logic [KEY_W-1:0]      author_code_i;
  logic                  done_o;
  logic [STATUS_W-1:0]   status_o;
  logic [SLOT_IDX_W-1:0] slot_index_o;
  logic [KEY_W-1:0]      entry_id_o;
  logic [KEY_W-1:0]      entry_author_o;

  slot_scoreboard board;
  bit             gaps_on;

  slot_table_with_id_lookup_core dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .command_i      (command_i),
    .key_i          (key_i),
    .author_code_i  (author_code_i),
    .done_o         (done_o),
    .status_o       (status_o),
    .slot_index_o   (slot_index_o),
    .entry_id_o     (entry_id_o),
    .entry_author_o (entry_author_o)
  );

  always begin
    clk_i = 1'b0;
    #4;
    clk_i = 1'b1;
    #4;
  end

  always @(posedge clk_i) begin
    if (rst_ni && done_o)
      board.check_result(status_o, slot_index_o, entry_id_o, entry_author_o);
  end

  function automatic int pick_gap();
    int r;
    if (!gaps_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [KEY_W-1:0] pool_author();
    case ($urandom_range(0, 3))
      0:       return '0;
      1:       return '1;
      2:       return 16'h0001;
      default: return 16'h8000;
    endcase
  endfunction

  function automatic logic [KEY_W-1:0] pick_author();
    return ($urandom_range(0, 1) != 0) ? pool_author() : KEY_W'($urandom);
  endfunction

  // Mostly keys that hit a live slot; some stale ids and some pure noise.
  function automatic logic [KEY_W-1:0] pick_key(bit by_author);
    int j, r, k, n;
    j = $urandom_range(0, TABLE_SLOTS - 1);
    r = $urandom_range(0, 9);
    if (r < 6) begin
      for (k = 0; k < TABLE_SLOTS; k++) begin
        n = (j + k) % TABLE_SLOTS;
        if (board.valid[n]) return by_author ? board.authors[n] : board.ids[n];
      end
    end
    if (r < 8) return by_author ? pool_author() : board.ids[j];
    return KEY_W'($urandom);
  endfunction

  // One request: optional idle gap, then hold start until the core takes it.
  task automatic issue(logic [CMD_W-1:0] cmd, logic [KEY_W-1:0] key,
                       logic [KEY_W-1:0] au);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk_i);
      start         <= 1'b0;
      command_i     <= CMD_W'($urandom);
      key_i         <= KEY_W'($urandom);
      author_code_i <= KEY_W'($urandom);
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    start         <= 1'b1;
    command_i     <= cmd;
    key_i         <= key;
    author_code_i <= au;
    do @(posedge clk_i); while (busy);
    board.note_request(cmd, key, au);
  endtask

  task automatic random_item(int ins_w);
    int               r;
    logic [CMD_W-1:0] cmd;
    logic [KEY_W-1:0] key;
    key = KEY_W'($urandom);
    r   = $urandom_range(0, 99);
    if (r < ins_w) begin
      cmd = CMD_INSERT;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 3)       cmd = CMD_CLEAR;
      else if (r < 6)  cmd = ($urandom_range(0, 1) != 0) ? CMD_UNUSED_HI : CMD_UNUSED_LO;
      else if (r < 30) cmd = CMD_DELETE;
      else if (r < 55) cmd = CMD_FIND_ID;
      else if (r < 80) cmd = CMD_FIND_AUTH;
      else             cmd = CMD_UPDATE;
    end
    if (cmd == CMD_FIND_AUTH)
      key = pick_key(1'b1);
    else if (cmd == CMD_DELETE || cmd == CMD_FIND_ID || cmd == CMD_UPDATE)
      key = pick_key(1'b0);
    issue(cmd, key, pick_author());
  endtask

  initial begin
    #(20_000_000);
    $display("slot_table_with_id_lookup_core verification failed");
    $finish;
  end

  initial begin
    int ins_w;
    board         = new();
    gaps_on       = 1'b1;
    rst_ni        = 1'b0;
    start         = 1'b0;
    command_i     = '0;
    key_i         = '0;
    author_code_i = '0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // empty table: no slot is valid after reset, so nothing may match
    issue(CMD_FIND_ID,   16'h0000, 16'h0000);
    issue(CMD_FIND_AUTH, 16'h0000, 16'hFFFF);
    issue(CMD_DELETE,    16'h0000, 16'h0000);
    issue(CMD_UPDATE,    16'h0000, 16'hFFFF);
    issue(CMD_INSERT,    16'hFFFF, 16'hFFFF);
    issue(CMD_INSERT,    16'h0000, 16'h0000);
    issue(CMD_INSERT,    16'h5A5A, 16'hFFFF);
    issue(CMD_FIND_AUTH, 16'hFFFF, 16'h0000);
    issue(CMD_FIND_ID,   16'h0003, 16'h0000);
    issue(CMD_UPDATE,    16'h0002, 16'hFFFF);
    issue(CMD_DELETE,    16'h0001, 16'hFFFF);
    issue(CMD_FIND_AUTH, 16'hFFFF, 16'h0000);
    // freed slot 0 is reused before slot 3
    issue(CMD_INSERT,    16'h0000, 16'h1234);
    issue(CMD_DELETE,    16'hFFFF, 16'h0000);
    issue(CMD_FIND_ID,   16'hFFFF, 16'hFFFF);
    issue(CMD_UNUSED_LO, 16'hFFFF, 16'hFFFF);
    issue(CMD_UNUSED_HI, 16'h0002, 16'hFFFF);
    issue(CMD_CLEAR,     16'hFFFF, 16'hFFFF);
    // stale records after clear stay invisible
    issue(CMD_FIND_ID,   16'h0002, 16'h0000);
    issue(CMD_FIND_AUTH, 16'hFFFF, 16'h0000);
    issue(CMD_UPDATE,    16'h0003, 16'h0000);
    issue(CMD_INSERT,    16'h0000, 16'h8000);
    issue(CMD_FIND_ID,   16'h0005, 16'h0000);

    for (int n = 0; n < 400; n++) begin
      if (n % 50 == 0) begin
        gaps_on = ($urandom_range(0, 3) != 0);
        case ($urandom_range(0, 2))
          0:       ins_w = 20;
          1:       ins_w = 45;
          default: ins_w = 70;
        endcase
      end
      random_item(ins_w);
    end

    // fill the table, then hit the full path and matches in the last slot
    gaps_on = 1'b0;
    issue(CMD_CLEAR, KEY_W'($urandom), KEY_W'($urandom));
    repeat (TABLE_SLOTS) issue(CMD_INSERT, KEY_W'($urandom), pick_author());
    gaps_on = 1'b1;
    issue(CMD_INSERT,  16'h0000, 16'h4321);
    issue(CMD_DELETE,  board.ids[TABLE_SLOTS/2], 16'h0000);
    issue(CMD_INSERT,  16'h0000, 16'h4321);
    issue(CMD_FIND_ID, board.ids[TABLE_SLOTS-1], 16'h0000);
    issue(CMD_UPDATE,  board.ids[TABLE_SLOTS-1], 16'hFFFF);
    issue(CMD_DELETE,  board.ids[TABLE_SLOTS-1], 16'h0000);
    for (int n = 0; n < 30; n++) random_item(45);
    @(negedge clk_i);
    start <= 1'b0;

    while (board.pending.size() != 0) @(posedge clk_i);
    repeat (TABLE_SLOTS + 8) @(posedge clk_i);
    if (board.errors == 0) begin
      $display("slot_table_with_id_lookup_core verification clean");
    end else begin
      $display("slot_table_with_id_lookup_core verification failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
design/stwl_pkg.sv
design/stwl_rec_mem.sv
design/slot_table_with_id_lookup_core.sv
sim/tb_top.sv
